FILE: hw/rtl/bba_pkg.sv
`timescale 1ns / 1ps

package bba_pkg;

  // bitmap geometry
  localparam int MAX_BLOCKS = 4096;
  localparam int WORD_BITS  = 32;
  localparam int NUM_WORDS  = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int WORD_AW    = $clog2(NUM_WORDS);
  localparam int BIT_AW     = $clog2(WORD_BITS);

  // field widths
  localparam int CNT_W     = 13;
  localparam int IDX_W     = 12;
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;
  localparam int CNT_RESET = 4096;

  // register byte addresses
  localparam logic [PADDR_W-1:0] REG_BLOCK_COUNT = PADDR_W'(0);

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FREE,
    S_DONE
  } state_e;

  typedef struct packed {
    logic             operation;
    logic [IDX_W-1:0] target_block;
  } in_item_t;

  typedef struct packed {
    status_e          status;
    logic [IDX_W-1:0] allocated_index;
  } out_item_t;

  // memory access request from the sequencer
  typedef struct packed {
    logic                 ren;
    logic [WORD_AW-1:0]   raddr;
    logic                 wen;
    logic [WORD_AW-1:0]   waddr;
    logic [WORD_BITS-1:0] wdata;
  } mem_req_t;

endpackage

FILE: hw/rtl/bba_apb.sv
`timescale 1ns / 1ps

module bba_apb (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bba_pkg::PADDR_W-1:0]  paddr,
  input  logic [bba_pkg::PDATA_W-1:0]  pwdata,
  output logic [bba_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  output logic [bba_pkg::CNT_W-1:0]    block_count_o
);
  import bba_pkg::*;

  logic [CNT_W-1:0] block_count_q, block_count_d;
  logic             sel_count;

  // only bit 2 selects a register, low bits are byte offsets
  assign sel_count = (paddr[PADDR_W-1] == REG_BLOCK_COUNT[PADDR_W-1]);
  assign pready    = 1'b1;

  // register write on the access phase
  always_comb begin
    block_count_d = block_count_q;
    if (psel && penable && pwrite && sel_count) begin
      block_count_d = pwdata[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_count_q <= CNT_W'(CNT_RESET);
    end else begin
      block_count_q <= block_count_d;
    end
  end

  // read back
  always_comb begin
    prdata = '0;
    if (sel_count) begin
      prdata = PDATA_W'(block_count_q);
    end
  end

  assign block_count_o = block_count_q;

endmodule

FILE: hw/rtl/bba_mem.sv
`timescale 1ns / 1ps

module bba_mem (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  bba_pkg::mem_req_t               req_i,
  output logic [bba_pkg::WORD_BITS-1:0]   rword_o
);
  import bba_pkg::*;

  logic [WORD_BITS-1:0] mem_q [NUM_WORDS];
  logic [NUM_WORDS-1:0] row_vld_q;
  logic [WORD_BITS-1:0] rdata_q;
  logic                 rvld_q;

  // bitmap storage, one word per row
  always_ff @(posedge clk_i) begin
    if (req_i.wen) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.ren) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  // row valid bits stand in for clearing the bitmap after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      rvld_q    <= 1'b0;
    end else begin
      if (req_i.wen) begin
        row_vld_q[req_i.waddr] <= 1'b1;
      end
      if (req_i.ren) begin
        rvld_q <= row_vld_q[req_i.raddr];
      end
    end
  end

  // a never written row reads as all free
  assign rword_o = rvld_q ? rdata_q : '0;

endmodule

FILE: hw/rtl/bba_scan.sv
`timescale 1ns / 1ps

module bba_scan (
  input  logic [bba_pkg::WORD_BITS-1:0] word_i,
  input  logic [bba_pkg::WORD_AW-1:0]   word_idx_i,
  input  logic [bba_pkg::CNT_W-1:0]     eff_count_i,
  output logic                          found_o,
  output logic [bba_pkg::BIT_AW-1:0]    pos_o,
  output logic [bba_pkg::WORD_BITS-1:0] set_word_o
);
  import bba_pkg::*;

  logic [CNT_W-1:0]     base;
  logic [CNT_W-1:0]     rem;
  logic [WORD_BITS-1:0] masked;

  // blocks at or above the count look used
  assign base = CNT_W'({word_idx_i, BIT_AW'(0)});
  assign rem  = eff_count_i - base;

  always_comb begin
    for (int b = 0; b < WORD_BITS; b++) begin
      masked[b] = word_i[b] | (CNT_W'(b) >= rem);
    end
  end

  // lowest free bit
  always_comb begin
    pos_o = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (!masked[b]) begin
        pos_o = BIT_AW'(b);
      end
    end
  end

  assign found_o    = ~&masked;
  assign set_word_o = word_i | (WORD_BITS'(1) << pos_o);

endmodule

FILE: hw/rtl/bitmap_block_allocator_top.sv
`timescale 1ns / 1ps
// allocate: scans k bitmap words from word 0 in order, k = bitmap words scanned (1 .. 128),
//   one word a cycle through the single read port of the bitmap memory
// free: read, clear the bit, write back in range; out of range and allocate at zero count go straight to S_DONE
// one transaction in flight: no accept until the sequencer is back in S_IDLE
// results wait in an output register, so a new transaction is taken while one is held
// reset: all blocks free (row valid bits cleared at once), block_count 4096, no wait
module bitmap_block_allocator_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  bba_pkg::in_item_t            in_item_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output bba_pkg::out_item_t           out_item_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bba_pkg::PADDR_W-1:0]  paddr,
  input  logic [bba_pkg::PDATA_W-1:0]  pwdata,
  output logic [bba_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);
  import bba_pkg::*;

  state_e               state_q, state_d;
  logic [WORD_AW-1:0]   word_q, word_d;
  logic [BIT_AW-1:0]    bit_q, bit_d;
  out_item_t            res_q, res_d;
  logic                 out_valid_q, out_valid_d;
  out_item_t            out_q, out_d;

  logic [CNT_W-1:0]     block_count;
  logic [CNT_W-1:0]     eff_count;
  logic [CNT_W:0]       words_sum;
  logic [WORD_AW:0]     num_words;
  logic [WORD_AW:0]     word_nx;
  mem_req_t             mem_req;
  logic [WORD_BITS-1:0] rword;
  logic                 found;
  logic [BIT_AW-1:0]    pos;
  logic [WORD_BITS-1:0] set_word;
  logic                 out_free;
  logic                 out_load;

  bba_apb u_apb (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .block_count_o (block_count)
  );

  bba_mem u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (mem_req),
    .rword_o (rword)
  );

  bba_scan u_scan (
    .word_i      (rword),
    .word_idx_i  (word_q),
    .eff_count_i (eff_count),
    .found_o     (found),
    .pos_o       (pos),
    .set_word_o  (set_word)
  );

  // saturated count and number of words to scan
  assign eff_count = (block_count > CNT_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : block_count;
  assign words_sum = {1'b0, eff_count} + (CNT_W + 1)'(WORD_BITS - 1);
  assign num_words = words_sum[BIT_AW +: (WORD_AW + 1)];
  assign word_nx   = {1'b0, word_q} + (WORD_AW + 1)'(1);

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE);

  // sequencer: read, modify, write back
  always_comb begin
    state_d       = state_q;
    word_d        = word_q;
    bit_d         = bit_q;
    res_d         = res_q;
    out_load      = 1'b0;
    mem_req       = '0;
    mem_req.raddr = word_q;
    mem_req.waddr = word_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (in_item_i.operation == OP_ALLOC) begin
            if (num_words == '0) begin
              res_d   = '{status: ST_FULL, allocated_index: '0};
              state_d = S_DONE;
            end else begin
              mem_req.ren   = 1'b1;
              mem_req.raddr = '0;
              word_d        = '0;
              state_d       = S_SCAN;
            end
          end else begin
            if ({1'b0, in_item_i.target_block} >= eff_count) begin
              res_d   = '{status: ST_RANGE, allocated_index: '0};
              state_d = S_DONE;
            end else begin
              mem_req.ren   = 1'b1;
              mem_req.raddr = in_item_i.target_block[IDX_W-1 -: WORD_AW];
              word_d        = in_item_i.target_block[IDX_W-1 -: WORD_AW];
              bit_d         = in_item_i.target_block[BIT_AW-1:0];
              state_d       = S_FREE;
            end
          end
        end
      end
      S_SCAN: begin
        if (found) begin
          mem_req.wen   = 1'b1;
          mem_req.wdata = set_word;
          res_d         = '{status: ST_OK, allocated_index: IDX_W'({word_q, pos})};
          state_d       = S_DONE;
        end else if (word_nx >= num_words) begin
          res_d   = '{status: ST_FULL, allocated_index: '0};
          state_d = S_DONE;
        end else begin
          // fetch the next word while this one is checked
          mem_req.ren   = 1'b1;
          mem_req.raddr = word_nx[WORD_AW-1:0];
          word_d        = word_nx[WORD_AW-1:0];
        end
      end
      S_FREE: begin
        mem_req.wen   = 1'b1;
        mem_req.wdata = rword & ~(WORD_BITS'(1) << bit_q);
        res_d         = '{status: ST_OK, allocated_index: '0};
        state_d       = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    if (out_load) begin
      out_valid_d = 1'b1;
      out_d       = res_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
    bit_q  <= bit_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // a write back never shares a cycle with a read
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_req.wen && mem_req.ren))
    else $error("bitmap read and write in the same cycle");

  // the scan stays inside the configured words
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> ({1'b0, word_q} < num_words))
    else $error("scan beyond the last bitmap word");

  // a new result only follows the completion state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_DONE))
    else $error("result appeared without completion");

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import bba_pkg::*;

  // predicts every result from the bitmap and the block count, checks in order
  class alloc_scoreboard;
    bit               used_map [MAX_BLOCKS];
    logic [CNT_W-1:0] count_reg;
    out_item_t        expected_q [$];
    int               errors;

    function new();
      foreach (used_map[i]) used_map[i] = 1'b0;
      count_reg = CNT_W'(CNT_RESET);
      errors    = 0;
    endfunction

    function void set_count(logic [CNT_W-1:0] value);
      count_reg = value;
    endfunction

    // count saturates at the bitmap size
    function int unsigned live_count();
      return (count_reg > MAX_BLOCKS) ? MAX_BLOCKS : count_reg;
    endfunction

    // a random used block below the live count, or -1 when none is used
    function int pick_used_block();
      int unsigned n;
      int unsigned hits [$];
      n = live_count();
      for (int unsigned i = 0; i < n; i++) begin
        if (used_map[i]) hits.push_back(i);
      end
      if (hits.size() == 0) return -1;
      return hits[$urandom_range(hits.size() - 1)];
    endfunction

    // accepted request: first-fit allocate or free, queue the expected result
    function void note_request(in_item_t req);
      out_item_t   exp;
      int unsigned n;
      bit          found;
      n                   = live_count();
      exp.status          = ST_OK;
      exp.allocated_index = '0;
      if (req.operation == OP_ALLOC) begin
        found = 1'b0;
        for (int unsigned i = 0; i < n && !found; i++) begin
          if (!used_map[i]) begin
            used_map[i]         = 1'b1;
            exp.allocated_index = IDX_W'(i);
            found               = 1'b1;
          end
        end
        if (!found) exp.status = ST_FULL;
      end else if (req.target_block >= n) begin
        exp.status = ST_RANGE;
      end else begin
        used_map[req.target_block] = 1'b0;
      end
      expected_q.push_back(exp);
    endfunction

    // accepted result against the oldest expectation
    function void check_result(out_item_t got);
      out_item_t exp;
      if (expected_q.size() == 0) begin
        $error("unexpected result: status %0d allocated_index %0d",
               got.status, got.allocated_index);
        errors++;
        return;
      end
      exp = expected_q.pop_front();
      if (got.status !== exp.status) begin
        $error("status: expected %0d, actual %0d", exp.status, got.status);
        errors++;
      end
      if (got.allocated_index !== exp.allocated_index) begin
        $error("allocated_index: expected %0d, actual %0d",
               exp.allocated_index, got.allocated_index);
        errors++;
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  in_item_t            in_item_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  out_item_t           out_item_o;
  logic                psel        = 1'b0;
  logic                penable     = 1'b0;
  logic                pwrite      = 1'b0;
  logic [PADDR_W-1:0]  paddr       = '0;
  logic [PDATA_W-1:0]  pwdata      = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  alloc_scoreboard sb = new();

  int idle_pct      = 0;
  int stall_pct     = 0;
  int pressure_reqs = 0;
  int pressure_done = 0;
  int hold_left     = 0;

  // random phases: block count, share of allocates, idling mode
  int unsigned phase_count [12] = '{8, 40, 100, 4096, 0, 300, 8191, 17, 64, 33, 4096, 1000};
  int          phase_alloc [12] = '{55, 55, 60, 75, 50, 60, 60, 55, 55, 55, 75, 60};
  int          mode_idle   [4]  = '{0, 46, 0, 29};
  int          mode_stall  [4]  = '{0, 0, 46, 29};

  bitmap_block_allocator_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #10ms;
    $display("*** FAILED ***");
    $finish;
  end

  // result side: check transactions, random stall, long hold-off on request
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) sb.check_result(out_item_o);
      if (pressure_reqs != pressure_done) begin
        hold_left     = 300;
        pressure_done = pressure_done + 1;
      end
      if (hold_left > 0) begin
        hold_left   = hold_left - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  function automatic in_item_t make_item(op_e op, int unsigned idx);
    in_item_t req;
    req.operation    = op;
    req.target_block = IDX_W'(idx);
    return req;
  endfunction

  // allocates at the given share; frees mostly of used blocks, some in range at random, at the edge, or anywhere
  function automatic in_item_t random_request(int alloc_pct);
    in_item_t    req;
    int          pick;
    int unsigned n;
    int unsigned sel;
    req.target_block = IDX_W'($urandom());
    n = sb.live_count();
    if ($urandom_range(99) < alloc_pct) begin
      req.operation = OP_ALLOC;
      return req;
    end
    req.operation = OP_FREE;
    sel = $urandom_range(99);
    if (sel < 60) begin
      pick = sb.pick_used_block();
      if (pick >= 0) req.target_block = IDX_W'(pick);
    end else if (sel < 80) begin
      if (n > 0) req.target_block = IDX_W'($urandom_range(n - 1));
    end else if (sel < 90) begin
      if (n < MAX_BLOCKS) req.target_block = IDX_W'(n);
    end
    return req;
  endfunction

  // offer one transaction after a random gap and wait for it to be taken
  task automatic send_item(in_item_t req);
    int gap;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= req;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(req);
  endtask

  // stop offering and wait for every pending result
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // register write with junk above the 13 count bits, only while idle
  task automatic write_count(logic [CNT_W-1:0] value);
    drain();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_BLOCK_COUNT;
    pwdata  <= ($urandom() & ~32'h1FFF) | PDATA_W'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_count(value);
  endtask

  // main sequence
  initial begin
    int mode;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: double free, extremes of index, full bitmap, out of range
    send_item(make_item(OP_FREE, 0));
    send_item(make_item(OP_FREE, 4095));
    send_item(make_item(OP_ALLOC, 0));
    send_item(make_item(OP_ALLOC, 0));
    send_item(make_item(OP_ALLOC, 4095));
    send_item(make_item(OP_FREE, 1));
    send_item(make_item(OP_ALLOC, 0));
    send_item(make_item(OP_FREE, 1));
    send_item(make_item(OP_FREE, 1));
    write_count(CNT_W'(8));
    repeat (7) send_item(make_item(OP_ALLOC, 0));
    send_item(make_item(OP_FREE, 8));
    send_item(make_item(OP_FREE, 4095));
    send_item(make_item(OP_FREE, 7));
    send_item(make_item(OP_ALLOC, 0));
    // zero count: every allocate full, every free out of range
    write_count(CNT_W'(0));
    send_item(make_item(OP_ALLOC, 0));
    send_item(make_item(OP_FREE, 0));
    // count above the bitmap size saturates; low blocks still show as used
    write_count(CNT_W'(8191));
    send_item(make_item(OP_FREE, 4095));
    send_item(make_item(OP_ALLOC, 0));

    // random phases across counts and idling modes
    for (int p = 0; p < 12; p++) begin
      write_count(CNT_W'(phase_count[p]));
      mode       = p % 4;
      idle_pct   <= mode_idle[mode];
      stall_pct  <= mode_stall[mode];
      if (p == 5) pressure_reqs <= pressure_reqs + 1;
      repeat (86) send_item(random_request(phase_alloc[p]));
    end

    drain();
    repeat (140) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
